// ===== src/lqm_pkg.sv =====
// ---------------------------------------------------------------------------
// lqm_pkg
// Shared constants, sequencer types and the control store of the linked
// queue manager.
// ---------------------------------------------------------------------------
`default_nettype none

package lqm_pkg;

  localparam int POOL_SIZE   = 32;
  localparam int QUEUE_COUNT = 8;

  localparam int FUNC_W  = 3;
  localparam int QID_W   = 3;
  localparam int ENTRY_W = 5;

  localparam int PTR_W  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int QIDX_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

  typedef enum logic [FUNC_W-1:0] {
    F_ALLOC  = 3'd0,
    F_FREE   = 3'd1,
    F_INSERT = 3'd2,
    F_PEEK   = 3'd3,
    F_REMOVE = 3'd4,
    F_TAKE   = 3'd5
  } func_t;

  // control store addresses
  typedef enum logic [4:0] {
    S_END    = 5'd0,
    S_ALLOC0 = 5'd1,
    S_ALLOC1 = 5'd2,
    S_FREE0  = 5'd3,
    S_FREE1  = 5'd4,
    S_INS0   = 5'd5,
    S_INS1   = 5'd6,
    S_INS2   = 5'd7,
    S_INS3   = 5'd8,
    S_INSF   = 5'd9,
    S_PR0    = 5'd10,
    S_PR1    = 5'd11,
    S_UN0    = 5'd12,
    S_UN1    = 5'd13,
    S_TO0    = 5'd14,
    S_TO1    = 5'd15,
    S_TO2    = 5'd16,
    S_TO3    = 5'd17,
    S_TOHIT  = 5'd18
  } step_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_DONE,
    A_RD_FREE,
    A_ALLOC,
    A_FREE,
    A_RD_TAIL,
    A_INS_A,
    A_INS_B,
    A_INS_FIRST,
    A_TAKE_HEAD,
    A_RD_X,
    A_UNLINK,
    A_WALK_INIT,
    A_RD_CUR,
    A_STEP,
    A_HIT
  } act_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_FREE_EMPTY,
    C_E_BAD,
    C_QE_BAD,
    C_Q_EMPTY,
    C_Q_BAD,
    C_QEV_BAD,
    C_PEEK,
    C_CUR_HIT,
    C_WALK_MORE
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } ucode_t;

  // one control word per step: action, jump condition, jump target
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t uc;
    unique case (s)
      S_END:    uc = '{A_DONE,      C_NEXT,       S_END};
      S_ALLOC0: uc = '{A_RD_FREE,   C_FREE_EMPTY, S_END};
      S_ALLOC1: uc = '{A_ALLOC,     C_ALWAYS,     S_END};
      S_FREE0:  uc = '{A_NONE,      C_E_BAD,      S_END};
      S_FREE1:  uc = '{A_FREE,      C_ALWAYS,     S_END};
      S_INS0:   uc = '{A_NONE,      C_QE_BAD,     S_END};
      S_INS1:   uc = '{A_RD_TAIL,   C_Q_EMPTY,    S_INSF};
      S_INS2:   uc = '{A_INS_A,     C_NEXT,       S_END};
      S_INS3:   uc = '{A_INS_B,     C_ALWAYS,     S_END};
      S_INSF:   uc = '{A_INS_FIRST, C_ALWAYS,     S_END};
      S_PR0:    uc = '{A_RD_TAIL,   C_Q_BAD,      S_END};
      S_PR1:    uc = '{A_TAKE_HEAD, C_PEEK,       S_END};
      S_UN0:    uc = '{A_RD_X,      C_NEXT,       S_END};
      S_UN1:    uc = '{A_UNLINK,    C_ALWAYS,     S_END};
      S_TO0:    uc = '{A_WALK_INIT, C_QEV_BAD,    S_END};
      S_TO1:    uc = '{A_RD_CUR,    C_CUR_HIT,    S_TOHIT};
      S_TO2:    uc = '{A_STEP,      C_WALK_MORE,  S_TO1};
      S_TO3:    uc = '{A_NONE,      C_ALWAYS,     S_END};
      S_TOHIT:  uc = '{A_HIT,       C_ALWAYS,     S_UN0};
      default:  uc = '{A_DONE,      C_NEXT,       S_END};
    endcase
    return uc;
  endfunction

  function automatic step_t dispatch(input logic [FUNC_W-1:0] f);
    step_t s;
    unique case (f)
      F_ALLOC:  s = S_ALLOC0;
      F_FREE:   s = S_FREE0;
      F_INSERT: s = S_INS0;
      F_PEEK:   s = S_PR0;
      F_REMOVE: s = S_PR0;
      F_TAKE:   s = S_TO0;
      default:  s = S_END;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== src/lqm_ram.sv =====
// ---------------------------------------------------------------------------
// lqm_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module lqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/linked_queue_manager_with_free_list_core.sv =====
// ---------------------------------------------------------------------------
// linked_queue_manager_with_free_list_core
// Pool of linked entries with a LIFO free list and circular doubly linked
// queues, run by a microcoded sequencer over two link RAMs.
//
//   channel  | signals                                 | handshake
//   ---------+-----------------------------------------+---------------------
//   command  | func, queue_id, entry                   | start && !busy
//   result   | result_entry, found, queue_empty        | done, one cycle
//
// A take-out walks the queue from its tail and visits up to POOL_SIZE
// entries when the entry is absent. The link RAMs have a registered read,
// so every link lookup costs a control store step. busy drops with the
// final step, so a new word may be taken in the cycle that done is shown.
// Reset is synchronous; link RAMs need no clearing pass, per entry flags
// stand for the reset values until an entry is first written.
// ---------------------------------------------------------------------------
`default_nettype none

module linked_queue_manager_with_free_list_core import lqm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [FUNC_W-1:0]  func,
  input  logic [QID_W-1:0]   queue_id,
  input  logic [ENTRY_W-1:0] entry,
  output logic               done,
  output logic [ENTRY_W-1:0] result_entry,
  output logic               found,
  output logic               queue_empty
);

  // sequencer
  logic   run, run_next;
  step_t  upc, upc_next;
  ucode_t uc;
  act_t   act;
  logic   jump;
  logic   accept;

  // datapath registers
  logic [FUNC_W-1:0]  fn, fn_next;
  logic [QID_W-1:0]   q, q_next;
  logic [ENTRY_W-1:0] e, e_next;
  logic [PTR_W-1:0]   t, t_next;
  logic [PTR_W-1:0]   x, x_next;
  logic [PTR_W-1:0]   cur, cur_next;
  logic [PTR_W-1:0]   cnt, cnt_next;
  logic [PTR_W-1:0]   res, res_next;
  logic               hit, hit_next;

  logic [PTR_W-1:0]     free_head, free_head_next;
  logic                 free_nonempty, free_nonempty_next;
  logic [POOL_SIZE-1:0] free_last, free_last_next;
  logic [PTR_W-1:0]     tail [QUEUE_COUNT];
  logic [PTR_W-1:0]     tail_next [QUEUE_COUNT];
  logic [QUEUE_COUNT-1:0] qvalid, qvalid_next;

  // set while an entry still holds its reset link value
  logic [POOL_SIZE-1:0] nxt_init, nxt_init_next;
  logic [POOL_SIZE-1:0] prv_init, prv_init_next;

  logic               done_next;
  logic [ENTRY_W-1:0] result_entry_next;
  logic               found_next;
  logic               queue_empty_next;

  // link RAM ports
  logic             wn_en, wp_en;
  logic [PTR_W-1:0] wn_addr, wn_data, wp_addr, wp_data;
  logic [PTR_W-1:0] rn_addr, rp_addr;
  logic [PTR_W-1:0] nram_q, pram_q;
  logic [PTR_W-1:0] rn_addr_q;
  logic             rn_init_q, rp_init_q;

  logic [PTR_W-1:0]  nd, pd;
  logic              q_ok, e_ok, q_valid;
  logic [QIDX_W-1:0] qi;
  logic [PTR_W-1:0]  ep, tail_q;

  lqm_ram #(.WIDTH(PTR_W), .DEPTH(POOL_SIZE)) u_next_ram (
    .clk   (clk),
    .we    (wn_en),
    .waddr (wn_addr),
    .wdata (wn_data),
    .raddr (rn_addr),
    .rdata (nram_q)
  );

  lqm_ram #(.WIDTH(PTR_W), .DEPTH(POOL_SIZE)) u_prev_ram (
    .clk   (clk),
    .we    (wp_en),
    .waddr (wp_addr),
    .wdata (wp_data),
    .raddr (rp_addr),
    .rdata (pram_q)
  );

  assign busy   = run;
  assign accept = start && !run;
  assign uc     = ucode_rom(upc);
  assign act    = run ? uc.act : A_NONE;

  assign q_ok    = int'(q) < QUEUE_COUNT;
  assign e_ok    = int'(e) < POOL_SIZE;
  assign qi      = q[QIDX_W-1:0];
  assign ep      = PTR_W'(e);
  assign q_valid = qvalid[qi];
  assign tail_q  = tail[qi];

  // untouched entries read as the free chain order and a zero back link
  assign nd = rn_init_q ? ((rn_addr_q == PTR_W'(POOL_SIZE - 1)) ? '0 : rn_addr_q + 1'b1)
                        : nram_q;
  assign pd = rp_init_q ? '0 : pram_q;

  always_comb begin
    unique case (uc.cond)
      C_NEXT:       jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_FREE_EMPTY: jump = !free_nonempty;
      C_E_BAD:      jump = !e_ok;
      C_QE_BAD:     jump = !q_ok || !e_ok;
      C_Q_EMPTY:    jump = !q_valid;
      C_Q_BAD:      jump = !q_ok || !q_valid;
      C_QEV_BAD:    jump = !q_ok || !e_ok || !q_valid;
      C_PEEK:       jump = (fn == F_PEEK);
      C_CUR_HIT:    jump = (cur == ep);
      C_WALK_MORE:  jump = !((nd == t) || (cnt == PTR_W'(POOL_SIZE - 1)));
      default:      jump = 1'b0;
    endcase
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      upc <= S_END;
    end else begin
      run <= run_next;
      upc <= upc_next;
    end
  end

  always_comb begin
    run_next = run;
    upc_next = upc;
    if (accept) begin
      run_next = 1'b1;
      upc_next = dispatch(func);
    end else if (run) begin
      if (uc.act == A_DONE) begin
        run_next = 1'b0;
      end
      upc_next = jump ? uc.target : step_t'(upc + 1'b1);
    end
  end

  // datapath driven by the current control word
  always_comb begin
    fn_next            = fn;
    q_next             = q;
    e_next             = e;
    t_next             = t;
    x_next             = x;
    cur_next           = cur;
    cnt_next           = cnt;
    res_next           = res;
    hit_next           = hit;
    free_head_next     = free_head;
    free_nonempty_next = free_nonempty;
    free_last_next     = free_last;
    tail_next          = tail;
    qvalid_next        = qvalid;
    done_next          = 1'b0;
    result_entry_next  = result_entry;
    found_next         = found;
    queue_empty_next   = queue_empty;
    wn_en   = 1'b0;
    wn_addr = '0;
    wn_data = '0;
    wp_en   = 1'b0;
    wp_addr = '0;
    wp_data = '0;
    rn_addr = '0;
    rp_addr = '0;

    if (accept) begin
      fn_next  = func;
      q_next   = queue_id;
      e_next   = entry;
      res_next = '0;
      hit_next = 1'b0;
    end

    unique case (act)
      A_NONE: begin
      end
      A_DONE: begin
        done_next         = 1'b1;
        result_entry_next = hit ? ENTRY_W'(res) : '0;
        found_next        = hit;
        queue_empty_next  = !(q_ok && q_valid);
      end
      A_RD_FREE: begin
        rn_addr = free_head;
        x_next  = free_head;
      end
      A_ALLOC: begin
        if (free_last[x]) begin
          free_nonempty_next = 1'b0;
        end else begin
          free_head_next = nd;
        end
        free_last_next[x] = 1'b0;
        wn_en    = 1'b1;
        wn_addr  = x;
        wp_en    = 1'b1;
        wp_addr  = x;
        res_next = x;
        hit_next = 1'b1;
      end
      A_FREE: begin
        wn_en   = 1'b1;
        wn_addr = ep;
        wn_data = free_head;
        wp_en   = 1'b1;
        wp_addr = ep;
        free_last_next[ep] = !free_nonempty;
        free_head_next     = ep;
        free_nonempty_next = 1'b1;
      end
      A_RD_TAIL: begin
        rp_addr = tail_q;
        t_next  = tail_q;
      end
      A_INS_A: begin
        wn_en   = 1'b1;
        wn_addr = ep;
        wn_data = t;
        wp_en   = 1'b1;
        wp_addr = ep;
        wp_data = pd;
        x_next  = pd;
      end
      A_INS_B: begin
        wn_en   = 1'b1;
        wn_addr = x;
        wn_data = ep;
        wp_en   = 1'b1;
        wp_addr = t;
        wp_data = ep;
        tail_next[qi] = ep;
      end
      A_INS_FIRST: begin
        wn_en   = 1'b1;
        wn_addr = ep;
        wn_data = ep;
        wp_en   = 1'b1;
        wp_addr = ep;
        wp_data = ep;
        qvalid_next[qi] = 1'b1;
        tail_next[qi]   = ep;
      end
      A_TAKE_HEAD: begin
        x_next   = pd;
        res_next = pd;
        hit_next = 1'b1;
      end
      A_RD_X: begin
        rn_addr = x;
        rp_addr = x;
      end
      A_UNLINK: begin
        // a self link means x was the only entry of the ring
        if (nd == x) begin
          qvalid_next[qi] = 1'b0;
        end else begin
          wn_en   = 1'b1;
          wn_addr = pd;
          wn_data = nd;
          wp_en   = 1'b1;
          wp_addr = nd;
          wp_data = pd;
          if (tail_q == x) begin
            tail_next[qi] = nd;
          end
        end
      end
      A_WALK_INIT: begin
        t_next   = tail_q;
        cur_next = tail_q;
        cnt_next = '0;
      end
      A_RD_CUR: begin
        rn_addr = cur;
      end
      A_STEP: begin
        cur_next = nd;
        cnt_next = cnt + 1'b1;
      end
      A_HIT: begin
        x_next   = ep;
        res_next = ep;
        hit_next = 1'b1;
      end
    endcase

    if (wn_en) begin
      nxt_init_next = nxt_init;
      nxt_init_next[wn_addr] = 1'b0;
    end else begin
      nxt_init_next = nxt_init;
    end
    if (wp_en) begin
      prv_init_next = prv_init;
      prv_init_next[wp_addr] = 1'b0;
    end else begin
      prv_init_next = prv_init;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head     <= '0;
      free_nonempty <= 1'b1;
      free_last     <= {1'b1, {(POOL_SIZE - 1){1'b0}}};
      tail          <= '{default: '0};
      qvalid        <= '0;
      nxt_init      <= '1;
      prv_init      <= '1;
      done          <= 1'b0;
    end else begin
      free_head     <= free_head_next;
      free_nonempty <= free_nonempty_next;
      free_last     <= free_last_next;
      tail          <= tail_next;
      qvalid        <= qvalid_next;
      nxt_init      <= nxt_init_next;
      prv_init      <= prv_init_next;
      done          <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    fn           <= fn_next;
    q            <= q_next;
    e            <= e_next;
    t            <= t_next;
    x            <= x_next;
    cur          <= cur_next;
    cnt          <= cnt_next;
    res          <= res_next;
    hit          <= hit_next;
    result_entry <= result_entry_next;
    found        <= found_next;
    queue_empty  <= queue_empty_next;
    rn_addr_q    <= rn_addr;
    rn_init_q    <= nxt_init[rn_addr];
    rp_init_q    <= prv_init[rp_addr];
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("sequencer did not start on an accepted word");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while the sequencer still runs");

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding operation");

  a_end_step: assert property (@(posedge clk) disable iff (rst)
    (busy && upc == S_END) |=> !busy)
    else $error("final step did not release the sequencer");

endmodule

`default_nettype wire
